FILE: hdl/assert_macros.svh
// assertion macros shared by the scanner rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/frsc_pkg.sv
// types, codes and constants of the fasta record length scanner
// no dependencies; imported by every scanner module but frsc_fifo
package frsc_pkg;

    // fixed field widths
    localparam int LEN_W   = 15;
    localparam int CNT_W   = 31;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [LEN_W-1:0] SPACE_MAX = {LEN_W{1'b1}};

    // defaults handed to the top level
    localparam int MAX_LINE_DEF  = 20000;
    localparam int CMD_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 4;

    // bytes with a fixed meaning
    localparam logic [BYTE_W-1:0] BYTE_NL          = 8'd10;
    localparam logic [BYTE_W-1:0] COMMENT_CHAR_RST = 8'd59;
    localparam logic [BYTE_W-1:0] HEADER_CHAR_RST  = 8'd62;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd1;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TOO_LONG  = 2'd1,
        ERR_NO_HEADER = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CLS_START   = 2'd0,
        CLS_HEADER  = 2'd1,
        CLS_SEQ     = 2'd2,
        CLS_COMMENT = 2'd3
    } line_class_t;

    // classified input beat, front to back
    typedef struct packed {
        logic eos;
        logic is_nl;
        logic is_space;
        logic is_comment;
        logic is_header;
    } cmd_t;

    // one result beat
    typedef struct packed {
        kind_t            kind;
        logic [CNT_W-1:0] record_index;
        logic [LEN_W-1:0] desc_length;
        logic [CNT_W-1:0] seq_length;
        err_t             error_code;
        logic [CNT_W-1:0] line_number;
        logic             last;
    } result_t;

endpackage

FILE: hdl/fasta_record_length_scanner_unit.sv
// top level of the fasta record length scanner
// depends on frsc_pkg, frsc_front, frsc_fifo and frsc_back
//
// Takes one byte per cycle on a push/full queue port while full is low, and
// returns record, done and error beats on an empty/pop queue port. Every data
// byte passes the classifier, a command queue of CMD_DEPTH entries, and the
// executor, which finishes one command per clock unless the result queue is
// full or a done beat waits; an end of stream that yields both a record and a
// done beat holds the executor until the done beat is written. A result goes
// from the executor into the result queue (RES_DEPTH entries), from which it
// is popped. comment_char and header_char are written through the cfg port
// while the block is idle: the user must keep to this, the block itself does
// not enforce it. Indexes beyond them are ignored.
module fasta_record_length_scanner_unit
    import frsc_pkg::*;
#(
    parameter int MAX_LINE  = MAX_LINE_DEF,
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [BYTE_W-1:0]    data_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           kind,
    output logic [CNT_W-1:0]     record_index,
    output logic [LEN_W-1:0]     desc_length,
    output logic [CNT_W-1:0]     seq_length,
    output logic [1:0]           error_code,
    output logic [CNT_W-1:0]     line_number,
    output logic                 last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata
);

    cmd_t                 front_cmd;
    logic [$bits(cmd_t)-1:0]    cmd_q;
    logic                 cmd_full, cmd_empty, cmd_pop;
    result_t              back_res;
    logic                 res_wr, res_full, res_empty;
    logic [$bits(result_t)-1:0] res_q;
    result_t              out_beat;

    // classifier and registers
    frsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .data_byte (data_byte),
        .cmd       (front_cmd)
    );

    // command queue between front and back
    frsc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !cmd_full),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_q),
        .empty   (cmd_empty)
    );

    // executor
    frsc_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_t'(cmd_q)),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (back_res)
    );

    // result queue
    frsc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop && !res_empty),
        .rd_data (res_q),
        .empty   (res_empty)
    );

    assign full     = cmd_full;
    assign empty    = res_empty;
    assign out_beat = result_t'(res_q);

    assign kind         = out_beat.kind;
    assign record_index = out_beat.record_index;
    assign desc_length  = out_beat.desc_length;
    assign seq_length   = out_beat.seq_length;
    assign error_code   = out_beat.error_code;
    assign line_number  = out_beat.line_number;
    assign last         = out_beat.last;

endmodule

FILE: hdl/frsc_fifo.sv
// small show-ahead queue used between the scanner stages
// no package dependency; uses assert_macros.svh
`include "assert_macros.svh"

module frsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "fifo count beyond depth")
    `ASSERT_IMPL(a_no_overflow, wr_en, !full || rd_en, "fifo written while full")
    `ASSERT_IMPL(a_no_underflow, rd_en, !empty, "fifo read while empty")

endmodule

FILE: hdl/frsc_front.sv
// front stage: configuration registers and byte classification
// depends on frsc_pkg
module frsc_front
    import frsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic                 op,
    input  logic [BYTE_W-1:0]    data_byte,
    output cmd_t                 cmd
);

    logic [BYTE_W-1:0] comment_char_reg;
    logic [BYTE_W-1:0] header_char_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_char_reg <= COMMENT_CHAR_RST;
            header_char_reg  <= HEADER_CHAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMMENT: comment_char_reg <= cfg_wdata;
                CFG_HEADER:  header_char_reg  <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // classify the incoming beat
    always_comb
    begin
        cmd.eos        = op;
        cmd.is_nl      = (data_byte == BYTE_NL);
        cmd.is_space   = data_byte inside {8'd32, [8'd9:8'd13]};
        cmd.is_comment = (data_byte == comment_char_reg);
        cmd.is_header  = (data_byte == header_char_reg);
    end

endmodule

FILE: hdl/frsc_back.sv
// back stage: line and record state, builds the result beats
// depends on frsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module frsc_back
    import frsc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    res_full,
    output logic    res_wr,
    output result_t res
);

    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_LINE);
    localparam logic [LEN_W+1:0] MAX_LEN2 = (LEN_W + 2)'(MAX_LINE);

    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [LEN_W-1:0] pend_space_reg, pend_space_next;
    line_class_t      line_class_reg, line_class_next;
    logic [CNT_W-1:0] line_count_reg, line_count_next;
    logic [CNT_W-1:0] rec_count_reg, rec_count_next;
    logic [LEN_W-1:0] desc_len_reg, desc_len_next;
    logic [CNT_W-1:0] seq_len_reg, seq_len_next;
    logic             failed_reg, failed_next;
    logic             done_pend_reg, done_pend_next;
    logic [CNT_W-1:0] done_count_reg, done_count_next;

    logic             fire;
    logic [CNT_W-1:0] fl_count;
    logic             fl_long, fl_no_header, fl_err, fl_open, fl_add_seq;
    err_t             fl_code;
    logic [CNT_W:0]   seq_sum;
    logic [CNT_W-1:0] seq_sat;
    logic [CNT_W-1:0] rc_inc;
    logic [LEN_W+1:0] len_sum;
    logic [LEN_W-1:0] len_new;
    line_class_t      cls_eff;
    logic             eos_finish;
    logic [CNT_W-1:0] rc_eos;
    logic [LEN_W-1:0] desc_eos;
    logic [CNT_W-1:0] seq_eos;

    function automatic result_t mk_result(kind_t k, logic [CNT_W-1:0] idx,
                                          logic [LEN_W-1:0] desc,
                                          logic [CNT_W-1:0] seq, err_t code,
                                          logic [CNT_W-1:0] line, logic lst);
        result_t r;
        r.kind         = k;
        r.record_index = idx;
        r.desc_length  = desc;
        r.seq_length   = seq;
        r.error_code   = code;
        r.line_number  = line;
        r.last         = lst;
        return r;
    endfunction

    // a command runs only with room for a result and no done beat waiting
    assign fire    = cmd_valid && !res_full && !done_pend_reg;
    assign cmd_pop = fire;

    // end-of-line evaluation, shared by newline and end of stream
    always_comb
    begin
        fl_count     = (line_count_reg == CNT_MAX) ? CNT_MAX : line_count_reg + 1'b1;
        fl_long      = (line_len_reg >= MAX_LEN);
        fl_no_header = (line_len_reg != '0) && (line_class_reg == CLS_SEQ)
                       && (rec_count_reg == '0);
        fl_err       = fl_long || fl_no_header;
        fl_code      = fl_long ? ERR_TOO_LONG : ERR_NO_HEADER;
        fl_open      = !fl_err && (line_len_reg != '0) && (line_class_reg == CLS_HEADER);
        fl_add_seq   = !fl_err && (line_len_reg != '0) && (line_class_reg == CLS_SEQ);
        seq_sum      = {1'b0, seq_len_reg} + {{(CNT_W + 1 - LEN_W){1'b0}}, line_len_reg};
        seq_sat      = seq_sum[CNT_W] ? CNT_MAX : seq_sum[CNT_W-1:0];
        rc_inc       = (rec_count_reg == CNT_MAX) ? CNT_MAX : rec_count_reg + 1'b1;
    end

    // data byte path: line class and trimmed length
    always_comb
    begin
        if (line_class_reg != CLS_START)
        begin
            cls_eff = line_class_reg;
        end
        else if (cmd.is_comment)
        begin
            cls_eff = CLS_COMMENT;
        end
        else if (cmd.is_header)
        begin
            cls_eff = CLS_HEADER;
        end
        else
        begin
            cls_eff = CLS_SEQ;
        end
        len_sum = {2'b00, line_len_reg} + {2'b00, pend_space_reg} + (LEN_W + 2)'(1);
        len_new = (len_sum >= MAX_LEN2) ? MAX_LEN : len_sum[LEN_W-1:0];
    end

    // record contents as seen at end of stream
    always_comb
    begin
        eos_finish = (line_class_reg != CLS_START);
        rc_eos     = (eos_finish && fl_open) ? rc_inc : rec_count_reg;
        desc_eos   = (eos_finish && fl_open) ? line_len_reg - 1'b1 : desc_len_reg;
        if (eos_finish && fl_open)
        begin
            seq_eos = '0;
        end
        else if (eos_finish && fl_add_seq)
        begin
            seq_eos = seq_sat;
        end
        else
        begin
            seq_eos = seq_len_reg;
        end
    end

    // next state and result beat
    always_comb
    begin
        line_len_next   = line_len_reg;
        pend_space_next = pend_space_reg;
        line_class_next = line_class_reg;
        line_count_next = line_count_reg;
        rec_count_next  = rec_count_reg;
        desc_len_next   = desc_len_reg;
        seq_len_next    = seq_len_reg;
        failed_next     = failed_reg;
        done_pend_next  = done_pend_reg;
        done_count_next = done_count_reg;
        res_wr          = 1'b0;
        res             = mk_result(KIND_DONE, done_count_reg, '0, '0, ERR_NONE, '0, 1'b1);

        if (done_pend_reg)
        begin
            // second beat of an end of stream
            if (!res_full)
            begin
                res_wr         = 1'b1;
                done_pend_next = 1'b0;
            end
        end
        else if (fire && cmd.eos)
        begin
            if (!failed_reg)
            begin
                res_wr = 1'b1;
                if (eos_finish && fl_err)
                begin
                    res = mk_result(KIND_ERROR, '0, '0, '0, fl_code, fl_count, 1'b1);
                end
                else if (rc_eos != '0)
                begin
                    res = mk_result(KIND_RECORD, rc_eos - 1'b1, desc_eos, seq_eos,
                                    ERR_NONE, '0, 1'b0);
                    done_pend_next  = 1'b1;
                    done_count_next = rc_eos;
                end
                else
                begin
                    res = mk_result(KIND_DONE, '0, '0, '0, ERR_NONE, '0, 1'b1);
                end
            end
            line_len_next   = '0;
            pend_space_next = '0;
            line_class_next = CLS_START;
            line_count_next = '0;
            rec_count_next  = '0;
            desc_len_next   = '0;
            seq_len_next    = '0;
            failed_next     = 1'b0;
        end
        else if (fire && !failed_reg)
        begin
            if (cmd.is_nl)
            begin
                line_count_next = fl_count;
                line_len_next   = '0;
                pend_space_next = '0;
                line_class_next = CLS_START;
                if (fl_err)
                begin
                    failed_next = 1'b1;
                    res_wr      = 1'b1;
                    res = mk_result(KIND_ERROR, '0, '0, '0, fl_code, fl_count, 1'b1);
                end
                else if (fl_open)
                begin
                    desc_len_next  = line_len_reg - 1'b1;
                    seq_len_next   = '0;
                    rec_count_next = rc_inc;
                end
                else if (fl_add_seq)
                begin
                    seq_len_next = seq_sat;
                end
            end
            else
            begin
                line_class_next = cls_eff;
                if (cmd.is_space)
                begin
                    pend_space_next = (pend_space_reg == SPACE_MAX) ?
                                      SPACE_MAX : pend_space_reg + 1'b1;
                end
                else
                begin
                    line_len_next   = len_new;
                    pend_space_next = '0;
                    // first visible byte of a header closes the previous record
                    if (cls_eff == CLS_HEADER && line_len_reg == '0 && rec_count_reg != '0)
                    begin
                        res_wr = 1'b1;
                        res = mk_result(KIND_RECORD, rec_count_reg - 1'b1, desc_len_reg,
                                        seq_len_reg, ERR_NONE, '0, 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            pend_space_reg <= '0;
            line_class_reg <= CLS_START;
            line_count_reg <= '0;
            rec_count_reg  <= '0;
            desc_len_reg   <= '0;
            seq_len_reg    <= '0;
            failed_reg     <= 1'b0;
            done_pend_reg  <= 1'b0;
            done_count_reg <= '0;
        end
        else
        begin
            line_len_reg   <= line_len_next;
            pend_space_reg <= pend_space_next;
            line_class_reg <= line_class_next;
            line_count_reg <= line_count_next;
            rec_count_reg  <= rec_count_next;
            desc_len_reg   <= desc_len_next;
            seq_len_reg    <= seq_len_next;
            failed_reg     <= failed_next;
            done_pend_reg  <= done_pend_next;
            done_count_reg <= done_count_next;
        end
    end

    `ASSERT_IMPL(a_wr_room, res_wr, !res_full, "result written into a full queue")
    `ASSERT_IMPL(a_silent_after_error, fire && failed_reg && !cmd.eos, !res_wr,
                 "result produced after an error")
    `ASSERT_ALWAYS(a_len_bound, line_len_reg <= MAX_LEN, "line length beyond its cap")
    `ASSERT_NEXT(a_done_follows, fire && done_pend_next, done_pend_reg && !cmd_pop,
                 "done beat not held after record at end of stream")

endmodule

FILE: sim/fasta_record_length_scanner_unit_tb.sv
// testbench for the fasta record length scanner: directed streams, marker settings,
// back-pressure and random streams checked against an in-bench predictor
// depends on frsc_pkg and fasta_record_length_scanner_unit
`timescale 1ns / 100ps

module fasta_record_length_scanner_unit_tb;
    import frsc_pkg::*;

    // input op codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // bytes used by the stream builders
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'd0;

    localparam int unsigned LINE_LIMIT  = MAX_LINE_DEF;
    localparam int unsigned SPACE_LIMIT = int'(SPACE_MAX);
    localparam int unsigned COUNT_LIMIT = int'(CNT_MAX);
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 120;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    logic                 op        = OP_DATA;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic [1:0]           kind;
    logic [CNT_W-1:0]     record_index;
    logic [LEN_W-1:0]     desc_length;
    logic [CNT_W-1:0]     seq_length;
    logic [1:0]           error_code;
    logic [CNT_W-1:0]     line_number;
    logic                 last;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COMMENT;
    logic [BYTE_W-1:0]    cfg_wdata = '0;

    // idling control
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    logic rx_hold     = 1'b0;

    int mismatch_count = 0;
    int beats_sent     = 0;

    // expected result beats, oldest first
    result_t expected_beats[$];
    result_t step_beats[$];

    // mirrored marker registers and scanner state
    logic [BYTE_W-1:0] comment_mark;
    logic [BYTE_W-1:0] header_mark;
    int unsigned       line_len_q;
    int unsigned       pend_space_q;
    line_class_t       line_cls_q;
    int unsigned       line_count_q;
    int unsigned       record_count_q;
    int unsigned       desc_len_q;
    int unsigned       seq_len_q;
    bit                failed_q;

    fasta_record_length_scanner_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .record_index (record_index),
        .desc_length  (desc_length),
        .seq_length   (seq_length),
        .error_code   (error_code),
        .line_number  (line_number),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned cap);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > cap) ? cap : int'(s);
    endfunction

    function automatic bit is_blank(logic [BYTE_W-1:0] b);
        return (b == BYTE_SPACE) || (b >= BYTE_TAB && b <= BYTE_CR);
    endfunction

    function automatic result_t make_beat(kind_t k, int unsigned idx, int unsigned dlen,
                                          int unsigned slen, err_t code, int unsigned ln);
        result_t r;
        r.kind         = k;
        r.record_index = idx[CNT_W-1:0];
        r.desc_length  = dlen[LEN_W-1:0];
        r.seq_length   = slen[CNT_W-1:0];
        r.error_code   = code;
        r.line_number  = ln[CNT_W-1:0];
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic void clear_scan_state();
        line_len_q     = 0;
        pend_space_q   = 0;
        line_cls_q     = CLS_START;
        line_count_q   = 0;
        record_count_q = 0;
        desc_len_q     = 0;
        seq_len_q      = 0;
        failed_q       = 1'b0;
    endfunction

    // close the current line: length check, then header/sequence bookkeeping
    function automatic void end_line();
        int unsigned len;
        line_class_t cls;
        len = line_len_q;
        cls = line_cls_q;
        line_count_q = sat_add(line_count_q, 1, COUNT_LIMIT);
        line_len_q   = 0;
        pend_space_q = 0;
        line_cls_q   = CLS_START;
        if (len >= LINE_LIMIT)
        begin
            failed_q = 1'b1;
            step_beats.push_back(make_beat(KIND_ERROR, 0, 0, 0, ERR_TOO_LONG, line_count_q));
        end
        else if (len != 0 && cls != CLS_COMMENT)
        begin
            if (cls == CLS_HEADER)
            begin
                desc_len_q     = len - 1;
                seq_len_q      = 0;
                record_count_q = sat_add(record_count_q, 1, COUNT_LIMIT);
            end
            else if (record_count_q == 0)
            begin
                failed_q = 1'b1;
                step_beats.push_back(make_beat(KIND_ERROR, 0, 0, 0, ERR_NO_HEADER,
                                               line_count_q));
            end
            else
                seq_len_q = sat_add(seq_len_q, len, COUNT_LIMIT);
        end
    endfunction

    // work out the result beats of one accepted input beat
    function automatic void predict_scan(logic o, logic [BYTE_W-1:0] b);
        int unsigned was;
        step_beats.delete();
        if (o == OP_EOS)
        begin
            if (!failed_q)
            begin
                if (line_cls_q != CLS_START)
                    end_line();
                if (!failed_q)
                begin
                    if (record_count_q > 0)
                        step_beats.push_back(make_beat(KIND_RECORD, record_count_q - 1,
                                                       desc_len_q, seq_len_q, ERR_NONE, 0));
                    step_beats.push_back(make_beat(KIND_DONE, record_count_q, 0, 0,
                                                   ERR_NONE, 0));
                end
            end
            clear_scan_state();
        end
        else if (!failed_q)
        begin
            if (b == BYTE_NL)
                end_line();
            else
            begin
                if (line_cls_q == CLS_START)
                begin
                    if (b == comment_mark)
                        line_cls_q = CLS_COMMENT;
                    else if (b == header_mark)
                        line_cls_q = CLS_HEADER;
                    else
                        line_cls_q = CLS_SEQ;
                end
                if (is_blank(b))
                    pend_space_q = sat_add(pend_space_q, 1, SPACE_LIMIT);
                else
                begin
                    was          = line_len_q;
                    line_len_q   = sat_add(line_len_q, pend_space_q + 1, LINE_LIMIT);
                    pend_space_q = 0;
                    // previous record goes out once the next header turns non-empty
                    if (line_cls_q == CLS_HEADER && was == 0 && record_count_q > 0)
                        step_beats.push_back(make_beat(KIND_RECORD, record_count_q - 1,
                                                       desc_len_q, seq_len_q, ERR_NONE, 0));
                end
            end
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // check each accepted result beat and drive pop for the next edge
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("result beat kind %0d with nothing expected",
                                              kind));
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("kind", kind, want.kind);
                    check_field("record_index", record_index, want.record_index);
                    check_field("desc_length", desc_length, want.desc_length);
                    check_field("seq_length", seq_length, want.seq_length);
                    check_field("error_code", error_code, want.error_code);
                    check_field("line_number", line_number, want.line_number);
                    check_field("last", last, want.last);
                end
            end
            pop <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------- input side

    // offer one beat, with random idle cycles first; push stays high on return
    task automatic send_beat(input logic o, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        op        <= o;
        data_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_scan(o, b);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_beat(OP_DATA, s[i]);
    endtask

    task automatic send_run(input logic [BYTE_W-1:0] b, input int count);
        repeat (count)
            send_beat(OP_DATA, b);
    endtask

    task automatic send_eos();
        send_beat(OP_EOS, BYTE_W'($urandom_range(255)));
    endtask

    // stop offering, wait for every expected beat, then let the pipeline empty
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COMMENT: comment_mark = val;
            CFG_HEADER:  header_mark  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_marks(input logic [BYTE_W-1:0] cmark, input logic [BYTE_W-1:0] hmark);
        wait_drained();
        write_reg(CFG_COMMENT, cmark);
        write_reg(CFG_HEADER, hmark);
    endtask

    // ---------------------------------------------------------------- random streams

    function automatic logic [BYTE_W-1:0] pick_seq_byte();
        string bases;
        int unsigned r;
        logic [BYTE_W-1:0] b;
        bases = "ACGTNacgtn";
        r = $urandom_range(99);
        if (r < 70)
            b = bases[$urandom_range(9)];
        else if (r < 85)
        begin
            r = $urandom_range(5);
            b = (r == 5) ? BYTE_SPACE : BYTE_TAB + r[BYTE_W-1:0];
        end
        else
        begin
            b = BYTE_W'($urandom_range(255));
            if (b == BYTE_NL)
                b = BYTE_ZERO;
        end
        return b;
    endfunction

    task automatic send_random_text(input int count);
        repeat (count)
            send_beat(OP_DATA, pick_seq_byte());
    endtask

    // newline, sometimes after a carriage return
    task automatic end_random_line();
        if ($urandom_range(3) == 0)
            send_beat(OP_DATA, BYTE_CR);
        send_beat(OP_DATA, BYTE_NL);
    endtask

    // comment, blank or whitespace-only line
    task automatic send_filler_line();
        case ($urandom_range(2))
            0:
            begin
                send_beat(OP_DATA, comment_mark);
                send_random_text($urandom_range(0, 6));
            end
            1: ;
            default: send_run(BYTE_SPACE, $urandom_range(1, 3));
        endcase
        end_random_line();
    endtask

    task automatic send_random_stream();
        int n_rec;
        // broken stream: sequence before any header, then ignored bytes
        if ($urandom_range(9) == 0)
        begin
            send_random_text($urandom_range(1, 6));
            send_beat(OP_DATA, BYTE_NL);
            send_random_text($urandom_range(0, 4));
            send_eos();
            return;
        end
        n_rec = $urandom_range(0, 4);
        for (int r = 0; r < n_rec; r++)
        begin
            if ($urandom_range(4) == 0)
                send_filler_line();
            send_beat(OP_DATA, header_mark);
            send_random_text($urandom_range(0, 8));
            end_random_line();
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(5) == 0)
                    send_filler_line();
                send_random_text($urandom_range(0, 12));
                end_random_line();
            end
        end
        // unterminated last line
        if ($urandom_range(3) == 0)
            send_random_text($urandom_range(1, 5));
        // sometimes the stream runs on into the next one
        if ($urandom_range(7) != 0)
            send_eos();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_basic_streams();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // empty stream
        send_eos();
        // one record
        send_text(">ab\nACGT\n");
        send_eos();
        // byte zero inside a sequence, two records, header with empty description
        send_text(">rec one\nAC");
        send_beat(OP_DATA, BYTE_ZERO);
        send_text("GT\n>\nTT\n");
        send_eos();
        // header at end of stream with no sequence
        send_text(">only");
        send_eos();
        wait_drained();
    endtask

    task automatic test_trimming_and_skips();
        // trailing and inner whitespace, comment, blank, whitespace-only, crlf
        send_text(">hd  \t\n;note\n\n   \nAC GT \r\nNN\t\n>x\n");
        send_beat(OP_DATA, BYTE_ZERO);
        send_text("\r\n  \n");
        send_eos();
        wait_drained();
    endtask

    task automatic test_error_paths();
        // sequence before header, later bytes ignored
        send_text("AC\n>h\nGG\n");
        send_eos();
        // comment first, then sequence with no header
        send_text(";c\n\nT");
        send_eos();
        // unterminated sequence line closed by end of stream
        send_text(">x\nAC");
        send_eos();
        wait_drained();
    endtask

    task automatic test_marker_settings();
        // header mark equal to comment mark: such lines are comments
        set_marks(8'd62, 8'd62);
        send_text(">x\nAC\n");
        send_eos();
        // whitespace header mark
        set_marks(8'd59, BYTE_SPACE);
        send_text(" ab \nAC\n   \n\tq\n");
        send_eos();
        // extreme marks
        set_marks(BYTE_ZERO, 8'hFF);
        send_beat(OP_DATA, 8'hFF);
        send_text("hd\n");
        send_beat(OP_DATA, BYTE_ZERO);
        send_text("x\nG\n");
        send_eos();
        set_marks(8'hFF, BYTE_ZERO);
        send_beat(OP_DATA, BYTE_ZERO);
        send_text("h\n");
        send_beat(OP_DATA, 8'hFF);
        send_text("c\nCA\n");
        send_eos();
        // spare indexes change nothing
        wait_drained();
        write_reg(CFG_SPARE_A, BYTE_W'($urandom_range(255)));
        write_reg(CFG_SPARE_B, BYTE_W'($urandom_range(255)));
        send_beat(OP_DATA, BYTE_ZERO);
        send_text("k\nAT\n");
        send_eos();
        // back to the reset marks
        set_marks(COMMENT_CHAR_RST, HEADER_CHAR_RST);
        send_text("> q\n;c\nA\n");
        send_eos();
        wait_drained();
    endtask

    // receiver holds off while short records keep coming, so both queues fill
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (30)
            send_text(">r\nACG\n");
        send_eos();
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [BYTE_W-1:0] cmark,
                                     input logic [BYTE_W-1:0] hmark, input int n_beats);
        int start;
        set_marks(cmark, hmark);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        start = beats_sent;
        while (beats_sent - start < n_beats)
            send_random_stream();
        send_eos();
        wait_drained();
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        comment_mark = COMMENT_CHAR_RST;
        header_mark  = HEADER_CHAR_RST;
        clear_scan_state();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_streams();
        test_trimming_and_skips();
        test_error_paths();
        test_marker_settings();
        test_backpressure();
        test_random_phase(0, 0, COMMENT_CHAR_RST, HEADER_CHAR_RST, 180);
        test_random_phase(59, 0, BYTE_ZERO, 8'hFF, 180);
        test_random_phase(0, 59, 8'hFF, BYTE_ZERO, 180);
        test_random_phase(12, 12, COMMENT_CHAR_RST, HEADER_CHAR_RST, 180);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
